@@ rtl/core/hdpp_pkg.sv @@
package hdpp_pkg;

    // line width limit (pixels), sets line store and page store depth
    localparam int MaxWidth  = 128;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int PairDepth = MaxWidth / 2;
    localparam int PairAw    = ColW - 1;
    localparam int WidthTop  = MaxWidth - (MaxWidth % 2);
    localparam int WUseW     = ColW + 1;

    localparam int RowW      = 8;
    localparam int HUseW     = RowW + 1;
    localparam int HeightMin = 8;
    localparam int HeightMax = 256;

    localparam int FwW       = 8;
    localparam int FhW       = 9;
    localparam int CfgIdxW   = 4;

    localparam logic [FwW-1:0] FwReset = 8'd128;
    localparam logic [FhW-1:0] FhReset = 9'd64;

    // pattern thresholds on the 2x2 average
    localparam logic [7:0] ThrBl = 8'd51;
    localparam logic [7:0] ThrTr = 8'd102;
    localparam logic [7:0] ThrBr = 8'd153;
    localparam logic [7:0] ThrTl = 8'd204;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [CfgIdxW-1:0] {
        REG_FRAME_WIDTH  = 4'd0,
        REG_FRAME_HEIGHT = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic             restart;
        logic [WUseW-1:0] w_use;
        logic [HUseW-1:0] h_use;
    } frame_cfg_t;

    // one finished column pair of a page
    typedef struct packed {
        logic       eof;
        logic [7:0] right;
        logic [7:0] left;
    } pair_t;

endpackage

@@ rtl/core/hdpp_front.sv @@
module hdpp_front
    import hdpp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  frame_cfg_t cfg,
    input  logic       pix_valid,
    output logic       pix_ready,
    input  logic [7:0] pix,
    output logic       pair_valid,
    input  logic       pair_ready,
    output pair_t      pair
);

    logic [ColW-1:0]   col_reg, col_next;
    logic [RowW-1:0]   row_reg, row_next;
    logic [7:0]        held_reg;

    logic [15:0]       ev_mem [PairDepth];
    logic [11:0]       pg_mem [PairDepth];
    logic [15:0]       ev_rd_reg;
    logic [11:0]       pg_rd_reg;

    logic              st_valid_reg;
    logic              st_calc_reg;
    logic              st_emit_reg;
    logic              st_eof_reg;
    logic [7:0]        st_px_reg;
    logic [PairAw-1:0] st_pair_reg;
    logic [1:0]        st_blk_reg;

    logic              fire;
    logic              advance;
    logic [PairAw-1:0] pair_idx;
    logic [WUseW-1:0]  col_inc;
    logic [HUseW-1:0]  row_inc;
    logic              wrap_col;
    logic              wrap_row;
    logic [9:0]        sum;
    logic [7:0]        avg;
    logic [3:0]        nib;   // {br, bl, tr, tl}
    logic [15:0]       blk_bits;

    assign fire     = pix_valid && pix_ready;
    assign pair_idx = col_reg[ColW-1:1];
    assign col_inc  = {1'b0, col_reg} + WUseW'(1);
    assign row_inc  = {1'b0, row_reg} + HUseW'(1);
    assign wrap_col = col_inc >= cfg.w_use;
    assign wrap_row = row_inc >= cfg.h_use;

    // stage holds unless it carries a pair the queue cannot take
    assign advance    = !st_valid_reg || !st_emit_reg || pair_ready;
    assign pix_ready  = advance;
    assign pair_valid = st_valid_reg && st_emit_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (fire) begin
            if (wrap_col) begin
                col_next = '0;
                row_next = wrap_row ? '0 : row_inc[RowW-1:0];
            end else begin
                col_next = col_inc[ColW-1:0];
            end
        end
        if (cfg.restart) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance) begin
                st_valid_reg <= fire;
            end
        end
    end

    // accept side: line store, held pixel, store reads
    always_ff @(posedge aclk) begin
        if (fire) begin
            if (!row_reg[0]) begin
                if (col_reg[0]) begin
                    ev_mem[pair_idx][15:8] <= pix;
                end else begin
                    ev_mem[pair_idx][7:0] <= pix;
                end
            end else if (!col_reg[0]) begin
                held_reg <= pix;
            end
            ev_rd_reg   <= ev_mem[pair_idx];
            pg_rd_reg   <= pg_mem[pair_idx];
            st_calc_reg <= row_reg[0] && col_reg[0];
            st_emit_reg <= row_reg[0] && col_reg[0] && (row_reg[2:0] == 3'b111);
            st_eof_reg  <= wrap_col && (col_inc == cfg.w_use) && (row_inc == cfg.h_use);
            st_px_reg   <= pix;
            st_pair_reg <= pair_idx;
            st_blk_reg  <= row_reg[2:1];
        end
    end

    // block average and pattern
    assign sum = 10'(ev_rd_reg[7:0]) + 10'(ev_rd_reg[15:8])
               + 10'(held_reg) + 10'(st_px_reg);
    assign avg = sum[9:2];
    assign nib = {avg >= ThrBr, avg >= ThrBl, avg >= ThrTr, avg >= ThrTl};

    // earlier block rows of the page from the store, last one live
    assign blk_bits = {nib, pg_rd_reg};

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            pair.left[2*b]    = blk_bits[4*b];
            pair.left[2*b+1]  = blk_bits[4*b+2];
            pair.right[2*b]   = blk_bits[4*b+1];
            pair.right[2*b+1] = blk_bits[4*b+3];
        end
        pair.eof = st_eof_reg;
    end

    always_ff @(posedge aclk) begin
        if (st_valid_reg && st_calc_reg && !st_emit_reg) begin
            pg_mem[st_pair_reg][{st_blk_reg, 2'b00} +: 4] <= nib;
        end
    end

endmodule

@@ rtl/core/hdpp_queue.sv @@
module hdpp_queue
    import hdpp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  pair_t in_pair,
    output logic  out_valid,
    input  logic  out_ready,
    output pair_t out_pair
);

    pair_t            buf_q [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg != QCntW'(QDepth);
    assign out_valid = cnt_reg != '0;
    assign out_pair  = buf_q[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCntW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCntW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_q[wr_ptr_reg] <= in_pair;
        end
    end

endmodule

@@ rtl/core/hdpp_back.sv @@
module hdpp_back
    import hdpp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pair_valid,
    output logic       pair_ready,
    input  pair_t      pair,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic  busy_reg;
    logic  second_reg;
    pair_t cur_reg;
    logic  take;

    // load a new pair when empty or as the second beat leaves
    assign take       = !busy_reg || (m_tready && second_reg);
    assign pair_ready = take;

    assign m_tvalid = busy_reg;
    assign m_tdata  = second_reg ? cur_reg.right : cur_reg.left;
    assign m_tlast  = second_reg;
    assign m_tuser  = second_reg && cur_reg.eof;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            second_reg <= 1'b0;
        end else if (take) begin
            busy_reg   <= pair_valid;
            second_reg <= 1'b0;
        end else if (m_tready) begin
            second_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && pair_valid) begin
            cur_reg <= pair;
        end
    end

endmodule

@@ rtl/core/halftone_dither_page_packer_top.sv @@
// Path: front stage register, then the queue, then the back end, which shows the left byte
//   of a pair on m_ and then its right byte. Throughput: one pixel per cycle unless the
//   front stage holds; one byte per cycle out while m_tready is high; a pair is made at
//   most every second pixel, so the 4-pair queue only absorbs downstream stalls.
// Reset: aresetn low at a clock edge empties the pipeline and queue, sets width 128,
//   height 64 and restarts the frame at row 0, column 0. Line store needs no clearing.
module halftone_dither_page_packer_top
    import hdpp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // config write port
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [FhW-1:0]     cfg_wdata,
    // pixel stream in
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] gray_pixel
    // page byte stream out
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] display_byte
    output logic               m_tlast,   // last_of_pair
    output logic               m_tuser    // [0] end_of_frame
);

    logic [FwW-1:0] fw_reg;
    logic [FhW-1:0] fh_reg;
    frame_cfg_t     cfg;

    logic  fq_valid, fq_ready;
    pair_t fq_pair;
    logic  qb_valid, qb_ready;
    pair_t qb_pair;

    // config registers; any known register write restarts the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FwReset;
            fh_reg <= FhReset;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  fw_reg <= cfg_wdata[FwW-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        int w;
        int h;
        w = int'(fw_reg);
        if (w < 2) w = 2;
        if (w > WidthTop) w = WidthTop;
        w = w - (w % 2);
        h = int'(fh_reg);
        if (h < HeightMin) h = HeightMin;
        if (h > HeightMax) h = HeightMax;
        h = h - (h % 8);
        cfg.w_use   = WUseW'(w);
        cfg.h_use   = HUseW'(h);
        cfg.restart = cfg_wr_en &&
                      ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));
    end

    // front: position tracking, line store, 2x2 pattern, page bit store
    hdpp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .pix_valid  (s_tvalid),
        .pix_ready  (s_tready),
        .pix        (s_tdata),
        .pair_valid (fq_valid),
        .pair_ready (fq_ready),
        .pair       (fq_pair)
    );

    // finished column pairs wait here so either side can stall
    hdpp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_pair   (fq_pair),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_pair  (qb_pair)
    );

    // back: splits each pair into two output beats
    hdpp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pair_valid (qb_valid),
        .pair_ready (qb_ready),
        .pair       (qb_pair),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

@@ rtl/core/hdpp_checker.sv @@
module hdpp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // output side comes up empty from reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // frame end only on the second byte of a pair
    a_eof_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame on first byte of pair");

    // a first byte is always followed by its partner
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("pair not completed");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled beat changed");

endmodule

bind halftone_dither_page_packer_top hdpp_checker u_hdpp_checker (.*);

@@ test/hdpp_page_checker.sv @@
`timescale 1ns / 1ps

// Watches the pixel, config and page-byte channels of the halftone page packer.
// It keeps its own copy of the frame state, predicts the page bytes of each
// accepted pixel and compares the byte beats in order.
module hdpp_page_checker
    import hdpp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [FhW-1:0]     cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,
    input  logic               m_tlast,
    input  logic               m_tuser,
    output int                 err_count,
    output int                 pending,
    output int                 byte_count,
    output int                 frame_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } page_beat_t;

    logic [FwW-1:0] width_reg;
    logic [FhW-1:0] height_reg;
    logic [7:0]     line_store [MaxWidth];
    logic [7:0]     page_bits  [MaxWidth];
    logic [7:0]     held_px;
    int             row_at;
    int             col_at;
    page_beat_t     page_byte_q [$];
    int             mismatches = 0;
    int             beats      = 0;
    int             frames     = 0;

    assign err_count   = mismatches;
    assign byte_count  = beats;
    assign frame_count = frames;

    task automatic restart_frame();
        row_at = 0;
        col_at = 0;
        foreach (page_bits[i]) page_bits[i] = 8'h00;
    endtask

    // one pixel through the dither and page packing
    task automatic dither_pixel(input logic [7:0] px);
        int         w;
        int         h;
        int         row;
        int         col;
        int         left;
        int         avg;
        int         top_bit;
        int         bot_bit;
        page_beat_t beat;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > WidthTop) w = WidthTop;
        w = w & ~1;
        h = height_reg;
        if (h < HeightMin) h = HeightMin;
        if (h > HeightMax) h = HeightMax;
        h = h & ~7;
        row = row_at;
        col = col_at;
        if (col >= w || col >= MaxWidth) col = 0;
        if (row >= h) row = 0;

        if (row % 2 == 0) begin
            line_store[col] = px;
        end else if (col % 2 == 0) begin
            held_px = px;
        end else begin
            left = col - 1;
            avg  = (int'(line_store[left]) + int'(line_store[col])
                    + int'(held_px) + int'(px)) >> 2;
            top_bit = (row - 1) % 8;
            bot_bit = row % 8;
            page_bits[left][top_bit] = (avg >= int'(ThrTl));
            page_bits[col][top_bit]  = (avg >= int'(ThrTr));
            page_bits[left][bot_bit] = (avg >= int'(ThrBl));
            page_bits[col][bot_bit]  = (avg >= int'(ThrBr));
            if (bot_bit == 7) begin
                beat.data = page_bits[left];
                beat.last = 1'b0;
                beat.eof  = 1'b0;
                page_byte_q.push_back(beat);
                beat.data = page_bits[col];
                beat.last = 1'b1;
                beat.eof  = (row == h - 1 && col == w - 1);
                page_byte_q.push_back(beat);
                page_bits[left] = 8'h00;
                page_bits[col]  = 8'h00;
            end
        end

        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_at = col;
        row_at = row;
    endtask

    task automatic check_beat();
        page_beat_t want;
        beats++;
        if (m_tuser === 1'b1) frames++;
        if (page_byte_q.size() == 0) begin
            $error("page byte %02h arrived with nothing expected", m_tdata);
            mismatches++;
        end else begin
            want = page_byte_q.pop_front();
            if (m_tdata !== want.data) begin
                $error("display_byte: expected %02h, got %02h", want.data, m_tdata);
                mismatches++;
            end
            if (m_tlast !== want.last) begin
                $error("last_of_pair: expected %0b, got %0b", want.last, m_tlast);
                mismatches++;
            end
            if (m_tuser !== want.eof) begin
                $error("end_of_frame: expected %0b, got %0b", want.eof, m_tuser);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = FwReset;
            height_reg = FhReset;
            held_px    = 8'h00;
            foreach (line_store[i]) line_store[i] = 8'h00;
            restart_frame();
            page_byte_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_beat();
            if (cfg_wr_en) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    width_reg = cfg_wdata[FwW-1:0];
                    restart_frame();
                end else if (cfg_index == REG_FRAME_HEIGHT) begin
                    height_reg = cfg_wdata;
                    restart_frame();
                end
            end
            if (s_tvalid && s_tready) dither_pixel(s_tdata);
        end
        pending <= page_byte_q.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import hdpp_pkg::*;

    // settle after the last byte: pipeline is ~3 deep, leave margin
    localparam int SettleCycles = 12;
    // long receiver hold-off, enough to fill the 4-pair queue and the pipeline
    localparam int HoldCycles   = 500;
    // index that maps to no register; a write there must change nothing
    localparam logic [CfgIdxW-1:0] RegSpare = '1;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [FhW-1:0]     cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;   // [7:0] gray_pixel
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [7:0]         m_tdata;             // [7:0] display_byte
    logic               m_tlast;             // last_of_pair
    logic               m_tuser;             // [0] end_of_frame

    int err_count;
    int pending;
    int byte_count;
    int frame_count;

    // stimulus knobs: idle percentages for each side
    int tx_pct      = 0;
    int rx_pct      = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int pixels_sent = 0;

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    halftone_dither_page_packer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    hdpp_page_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .err_count   (err_count),
        .pending     (pending),
        .byte_count  (byte_count),
        .frame_count (frame_count)
    );

    // Receiver. A new hold ticket from the stimulus starts a long hold-off;
    // otherwise ready is dropped at random at the rate rx_pct.
    always @(posedge aclk) begin
        if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= HoldCycles;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_pct);
        end
    end

    // Directed blocks packed {tl, tr, bl, br}. Averages sit on both sides of
    // every threshold, some of them only reached through truncation of the sum.
    function automatic logic [31:0] probe_block(input int b);
        case (b)
            0:       return {8'd200, 8'd200, 8'd200, 8'd215};  // 815 -> 203
            1:       return {8'd0,   8'd0,   8'd0,   8'd203};  // 203 -> 50
            2:       return {8'd0,   8'd0,   8'd0,   8'd204};  // 51
            3:       return {8'd101, 8'd101, 8'd101, 8'd104};  // 407 -> 101
            4:       return {8'd102, 8'd102, 8'd102, 8'd102};  // 102
            5:       return {8'd152, 8'd152, 8'd152, 8'd155};  // 611 -> 152
            6:       return {8'd153, 8'd153, 8'd153, 8'd153};  // 153
            default: return {8'd255, 8'd255, 8'd255, 8'd51};   // 816 -> 204
        endcase
    endfunction

    // Tone for a run of pixels: thresholds, rails, or anything.
    function automatic logic [7:0] pick_tone();
        case ($urandom_range(0, 7))
            0:       return ThrBl;
            1:       return ThrTr;
            2:       return ThrBr;
            3:       return ThrTl;
            4:       return 8'd0;
            5:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly near the tone so block averages land around a threshold,
    // one pixel in four fully random.
    function automatic logic [7:0] pick_gray(input logic [7:0] tone);
        int v;
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        v = int'(tone) + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // One pixel beat; gaps before it at the rate tx_pct.
    task automatic push_pixel(input logic [7:0] px);
        while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int n);
        logic [7:0] tone;
        tone = 8'd0;
        for (int k = 0; k < n; k++) begin
            if (k % 16 == 0) tone = pick_tone();
            push_pixel(pick_gray(tone));
        end
    endtask

    // Stop sending, wait for every predicted byte, then let the pipeline empty.
    // pending is registered, hence the first edge before looking at it.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [FhW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // width then height as back-to-back writes
    task automatic set_geometry(input logic [FhW-1:0] fw, input logic [FhW-1:0] fh);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_wdata <= fw;
        @(posedge aclk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_wdata <= fh;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // New frame geometry and idle rates, then n random pixels.
    task automatic run_setting(input logic [FhW-1:0] fw, input logic [FhW-1:0] fh,
                               input int tx, input int rx, input int n);
        wait_idle();
        set_geometry(fw, fh);
        tx_pct = tx;
        rx_pct <= rx;
        send_pixels(n);
    endtask

    // Run limit, far above the slowest legal run.
    initial begin
        #5_000_000;
        $error("timeout with %0d page bytes still expected", pending);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [31:0] blk;
        int          leftover;
        int          mode;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // a few pixels under the reset geometry (128x64); no page closes
        send_pixels(4);

        // directed frame, 4 wide and 8 tall: eight blocks, thresholds both sides
        wait_idle();
        set_geometry(9'd4, 9'd8);
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 4; c++) begin
                blk = probe_block((r / 2) * 2 + c / 2);
                push_pixel(blk[8 * (3 - ((r % 2) * 2 + c % 2)) +: 8]);
            end
        end

        // width 255 with bit 8 set clamps to 128; height 7 clamps to 8.
        // Short partial first row only; no page closes.
        run_setting(9'h1FF, 9'd7, 0, 0, 40);
        // width 0 clamps to 2; height 511 clamps to 256: three pages
        run_setting(9'd0, 9'h1FF, 0, 0, 48);
        // sender idle most cycles
        run_setting(9'd6, 9'd16, 88, 0, 100);
        // odd width 3 -> 2, height 13 -> 8, many row wraps; receiver stalls most cycles
        run_setting(9'd3, 9'd13, 0, 88, 100);

        // both sides idle at times; mid-run drain and a write to an unused
        // index, which must leave the frame position alone
        run_setting(9'd10, 9'd24, 21, 21, 50);
        wait_idle();
        write_reg(RegSpare, 9'h155);
        send_pixels(50);

        // back-pressure: receiver holds off while pixels keep coming,
        // so the queue fills and s_tready drops
        wait_idle();
        set_geometry(9'd2, 9'd8);
        tx_pct = 0;
        rx_pct <= 0;
        hold_ticket <= hold_ticket + 1;
        send_pixels(120);

        // short random geometries and idle mixes
        for (int p = 0; p < 6; p++) begin
            mode = $urandom_range(0, 3);
            run_setting(9'(2 * $urandom_range(1, 8)), 9'(8 * $urandom_range(1, 3)),
                        (mode == 1) ? 88 : (mode == 3) ? 21 : 0,
                        (mode == 2) ? 88 : (mode == 3) ? 21 : 0,
                        $urandom_range(16, 24));
        end

        wait_idle();
        leftover = pending;
        if (leftover != 0) $error("%0d page bytes never arrived", leftover);

        $display("Covered %0d pixels, %0d page bytes checked, %0d frame ends.",
                 pixels_sent, byte_count, frame_count);
        $display("Geometries from 2x8 up to 128 wide and 256 tall, with idling and hold-off.");
        if (err_count == 0 && leftover == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ halftone_dither_page_packer_top.f @@
rtl/core/hdpp_pkg.sv
rtl/core/hdpp_front.sv
rtl/core/hdpp_queue.sv
rtl/core/hdpp_back.sv
rtl/core/halftone_dither_page_packer_top.sv
rtl/core/hdpp_checker.sv
test/hdpp_page_checker.sv
test/tb_top.sv
